// File: design/circular_linked_queue_manager_defines.svh
// Assertion macros for the circular linked queue manager.
// Included by RTL files that carry concurrent checks; no other dependency.
`ifndef CIRCULAR_LINKED_QUEUE_MANAGER_DEFINES_SVH
`define CIRCULAR_LINKED_QUEUE_MANAGER_DEFINES_SVH
`ifndef SYNTHESIS
`define CLQ_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define CLQ_ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define CLQ_ASSERT(lbl, clk, rst_n, prop, msg)
`define CLQ_ASSERT_NEVER(lbl, clk, rst_n, cond, msg)
`endif
`endif

// File: design/clqm_pkg.sv
// Shared types and codes for the circular linked queue manager.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package clqm_pkg;
  typedef enum logic {
    KIND_APPEND = 1'b0,
    KIND_REMOVE = 1'b1
  } kind_e;

  typedef enum logic {
    STATUS_DONE     = 1'b0,
    STATUS_REJECTED = 1'b1
  } status_e;

  localparam int unsigned QidW  = 2;
  localparam int unsigned ElemW = 6;
  localparam int unsigned CntW  = 7;

  // One classified command between front and back.
  typedef struct packed {
    kind_e              kind;
    logic [QidW-1:0]    queue_id;
    logic [ElemW-1:0]   element;
    logic               bad;      // out-of-range queue or element
  } cmd_t;

  typedef struct packed {
    status_e            status;
    logic [ElemW-1:0]   head_index;
    logic               queue_empty;
    logic [CntW-1:0]    queue_count;
  } res_t;
endpackage
`default_nettype wire

// File: design/clqm_front.sv
// Front end: accepts requests, range-checks them and queues commands.
// Depends on clqm_pkg.
`timescale 1ns / 1ps
`default_nettype none
module clqm_front #(
  parameter int unsigned NUM_ELEMENTS = 64,
  parameter int unsigned NUM_QUEUES   = 4
) (
  input  wire                         clk_i,
  input  wire                         rst_ni,
  input  wire                         push_i,
  output logic                        full_o,
  input  wire                         kind_i,
  input  wire [clqm_pkg::QidW-1:0]    queue_id_i,
  input  wire [clqm_pkg::ElemW-1:0]   element_i,
  output logic                        cmd_valid_o,
  input  wire                         cmd_take_i,
  output clqm_pkg::cmd_t              cmd_o
);
  import clqm_pkg::*;
  `include "circular_linked_queue_manager_defines.svh"

  // Two-entry command queue.
  cmd_t       mem_q [2];
  logic       wr_q, wr_d, rd_q, rd_d;
  logic [1:0] cnt_q, cnt_d;
  cmd_t       in_cmd;
  logic       do_push;

  always_comb begin
    in_cmd.kind     = kind_e'(kind_i);
    in_cmd.queue_id = queue_id_i;
    in_cmd.element  = element_i;
    in_cmd.bad      = (32'(queue_id_i) >= NUM_QUEUES) || (32'(element_i) >= NUM_ELEMENTS);
  end

  assign full_o      = cnt_q[1];
  assign do_push     = push_i && !full_o;
  assign cmd_valid_o = cnt_q != 2'd0;
  assign cmd_o       = mem_q[rd_q];

  always_comb begin
    wr_d  = wr_q ^ do_push;
    rd_d  = rd_q ^ (cmd_take_i && cmd_valid_o);
    cnt_d = cnt_q + 2'(do_push) - 2'(cmd_take_i && cmd_valid_o);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= in_cmd;
    end
  end

  `CLQ_ASSERT_NEVER(a_cnt_range, clk_i, rst_ni, cnt_q == 2'd3, "command queue count overflow")
  `CLQ_ASSERT(a_take_nonempty, clk_i, rst_ni, (cnt_q == 2'd0) |=> (cnt_q != 2'd2),
              "command queue grew by two")
  `CLQ_ASSERT(a_ptr_match, clk_i, rst_ni, (cnt_q == 2'd0 || cnt_q == 2'd2) |-> (wr_q == rd_q),
              "command queue pointers disagree with count")
endmodule
`default_nettype wire

// File: design/clqm_back.sv
// Back end: runs append and remove against the link memories, one command
// at a time, and queues results. Depends on clqm_pkg.
`timescale 1ns / 1ps
`default_nettype none
module clqm_back #(
  parameter int unsigned NUM_ELEMENTS = 64,
  parameter int unsigned NUM_QUEUES   = 4
) (
  input  wire                         clk_i,
  input  wire                         rst_ni,
  input  wire                         cmd_valid_i,
  output logic                        cmd_take_o,
  input  clqm_pkg::cmd_t              cmd_i,
  output logic                        empty_o,
  input  wire                         pop_i,
  output logic                        status_o,
  output logic [clqm_pkg::ElemW-1:0]  head_index_o,
  output logic                        queue_empty_o,
  output logic [clqm_pkg::CntW-1:0]   queue_count_o
);
  import clqm_pkg::*;
  `include "circular_linked_queue_manager_defines.svh"

  localparam int unsigned AW = (NUM_ELEMENTS > 1) ? $clog2(NUM_ELEMENTS) : 1;
  localparam int unsigned QW = (NUM_QUEUES > 1) ? $clog2(NUM_QUEUES) : 1;
  localparam int unsigned WW = $clog2(NUM_ELEMENTS + 1);

  typedef enum logic [9:0] {
    ST_IDLE  = 10'b0000000001,
    ST_CLR   = 10'b0000000010,
    ST_DEC   = 10'b0000000100,
    ST_RDH   = 10'b0000001000,
    ST_APP   = 10'b0000010000,
    ST_WALK  = 10'b0000100000,
    ST_RDE   = 10'b0001000000,
    ST_UNL   = 10'b0010000000,
    ST_FIN   = 10'b0100000000,
    ST_OUT   = 10'b1000000000
  } state_e;

  state_e state_q, state_d;

  // Link memories, one write and one read port each, registered read.
  logic [AW-1:0] next_mem [NUM_ELEMENTS];
  logic [AW-1:0] prev_mem [NUM_ELEMENTS];
  logic          link_mem [NUM_ELEMENTS];
  logic          nx_we, pv_we, lk_we;
  logic [AW-1:0] nx_wa, nx_wd, pv_wa, pv_wd, lk_wa, nx_ra, pv_ra;
  logic          lk_wd;
  logic [AW-1:0] nx_rd_q, pv_rd_q;
  logic          lk_rd_q;

  logic [AW-1:0]   head_q   [NUM_QUEUES];
  logic            hval_q   [NUM_QUEUES];
  logic [CntW-1:0] count_q  [NUM_QUEUES];

  cmd_t          cmd_q;
  logic [AW-1:0] e_a, q_h, cur_q, cur_d, t_q, t_d, n_q, n_d;
  logic [WW-1:0] steps_q, steps_d;
  logic [QW-1:0] qi;
  logic          ok_q, ok_d;
  logic [AW-1:0] clr_q, clr_d;
  logic [2:0]    phase_q, phase_d;
  logic          hd_we, hd_v, cn_inc, cn_dec;
  logic [AW-1:0] hd_wd;

  // Result register.
  res_t          res_q;
  logic          res_v_q;
  logic          res_load;

  assign e_a = cmd_q.element[AW-1:0];
  assign qi  = cmd_q.queue_id[QW-1:0];
  assign q_h = head_q[qi];

  always_comb begin
    state_d  = state_q;
    cur_d    = cur_q;
    t_d      = t_q;
    n_d      = n_q;
    steps_d  = steps_q;
    ok_d     = ok_q;
    clr_d    = clr_q;
    phase_d  = phase_q;
    nx_we = 1'b0; nx_wa = e_a; nx_wd = '0;
    pv_we = 1'b0; pv_wa = e_a; pv_wd = '0;
    lk_we = 1'b0; lk_wa = e_a; lk_wd = 1'b0;
    nx_ra = e_a;  pv_ra = e_a;
    hd_we = 1'b0; hd_v = 1'b0; hd_wd = '0;
    cn_inc = 1'b0; cn_dec = 1'b0;
    cmd_take_o = 1'b0;
    res_load = 1'b0;
    case (state_q)
      ST_CLR: begin
        nx_we = 1'b1; nx_wa = clr_q;
        pv_we = 1'b1; pv_wa = clr_q;
        lk_we = 1'b1; lk_wa = clr_q;
        clr_d = clr_q + AW'(1);
        if (32'(clr_q) == NUM_ELEMENTS - 1) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (cmd_valid_i) begin
          cmd_take_o = 1'b1;
          state_d    = ST_DEC;
        end
      end
      ST_DEC: begin
        // Memory reads are issued here: next and linked at e, prev at the head.
        ok_d  = 1'b0;
        pv_ra = q_h;
        if (cmd_q.bad) begin
          state_d = ST_FIN;
        end else if (cmd_q.kind == KIND_APPEND) begin
          state_d = ST_RDH;
        end else if (!hval_q[qi]) begin
          state_d = ST_FIN;
        end else begin
          cur_d   = q_h;
          steps_d = '0;
          state_d = ST_WALK;
        end
      end
      ST_RDH: begin
        // lk_rd_q = linked[e], pv_rd_q = prev[head]
        if (lk_rd_q) begin
          state_d = ST_FIN;
        end else begin
          t_d     = pv_rd_q;
          phase_d = 3'd0;
          state_d = ST_APP;
        end
      end
      ST_APP: begin
        ok_d   = 1'b1;
        lk_we  = 1'b1; lk_wd = 1'b1;
        cn_inc = 1'b1;
        nx_we  = 1'b1; pv_we = 1'b1;
        if (!hval_q[qi]) begin
          nx_wd = e_a; pv_wd = e_a;
          hd_we = 1'b1; hd_v = 1'b1; hd_wd = e_a;
          state_d = ST_FIN;
        end else if (phase_q == 3'd0) begin
          lk_we = 1'b0; cn_inc = 1'b0;
          nx_wd = q_h; pv_wd = t_q;
          phase_d = 3'd1;
        end else begin
          nx_wa = t_q; nx_wd = e_a;
          pv_wa = q_h; pv_wd = e_a;
          state_d = ST_FIN;
        end
      end
      ST_WALK: begin
        // Compare cur; fetch next[cur], result lands next cycle.
        nx_ra = cur_q;
        if (cur_q == e_a) begin
          state_d = ST_RDE;
          phase_d = 3'd0;
        end else if (32'(steps_q) >= NUM_ELEMENTS - 1) begin
          state_d = ST_FIN;
        end else begin
          state_d = ST_RDE;
          phase_d = 3'd1;
        end
      end
      ST_RDE: begin
        // Either advance the walk (phase 1) or latch links of e (phase 0).
        if (phase_q == 3'd1) begin
          phase_d = 3'd0;
          if (nx_rd_q == q_h) begin
            state_d = ST_FIN;
          end else begin
            cur_d   = nx_rd_q;
            steps_d = steps_q + WW'(1);
            state_d = ST_WALK;
          end
        end else begin
          state_d = ST_UNL;
          phase_d = 3'd2;
        end
      end
      ST_UNL: begin
        if (phase_q == 3'd2) begin
          // Links of e were read at e during RDE.
          t_d = pv_rd_q;
          n_d = nx_rd_q;
          phase_d = 3'd3;
        end else begin
          ok_d   = 1'b1;
          cn_dec = 1'b1;
          if (phase_q == 3'd3 && n_q != e_a) begin
            nx_we = 1'b1; nx_wa = t_q; nx_wd = n_q;
            pv_we = 1'b1; pv_wa = n_q; pv_wd = t_q;
            cn_dec = 1'b0; ok_d = 1'b0;
            phase_d = 3'd4;
          end else begin
            nx_we = 1'b1; pv_we = 1'b1; lk_we = 1'b1;
            hd_we = (n_q == e_a) || (q_h == e_a);
            hd_v  = n_q != e_a;
            hd_wd = (n_q == e_a) ? '0 : n_q;
            state_d = ST_FIN;
          end
        end
      end
      ST_FIN: begin
        if (!res_v_q || pop_i) begin
          res_load = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (nx_we) next_mem[nx_wa] <= nx_wd;
    if (pv_we) prev_mem[pv_wa] <= pv_wd;
    if (lk_we) link_mem[lk_wa] <= lk_wd;
    nx_rd_q <= next_mem[nx_ra];
    pv_rd_q <= prev_mem[pv_ra];
    lk_rd_q <= link_mem[e_a];
    if (cmd_take_o) cmd_q <= cmd_i;
    cur_q   <= cur_d;
    t_q     <= t_d;
    n_q     <= n_d;
    steps_q <= steps_d;
    ok_q    <= ok_d;
    if (res_load) begin
      res_q.status      <= ok_q ? STATUS_DONE : STATUS_REJECTED;
      res_q.head_index  <= (cmd_q.bad && 32'(cmd_q.queue_id) >= NUM_QUEUES) ? '0 :
                           (hval_q[qi] ? ElemW'(q_h) : '0);
      res_q.queue_empty <= (32'(cmd_q.queue_id) >= NUM_QUEUES) ? 1'b1 : !hval_q[qi];
      res_q.queue_count <= (32'(cmd_q.queue_id) >= NUM_QUEUES) ? '0 : count_q[qi];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLR;
      clr_q   <= '0;
      phase_q <= '0;
      res_v_q <= 1'b0;
      for (int i = 0; i < NUM_QUEUES; i++) begin
        head_q[i]  <= '0;
        hval_q[i]  <= 1'b0;
        count_q[i] <= '0;
      end
    end else begin
      state_q <= state_d;
      clr_q   <= clr_d;
      phase_q <= phase_d;
      if (res_load) res_v_q <= 1'b1;
      else if (pop_i) res_v_q <= 1'b0;
      if (hd_we) begin
        head_q[qi] <= hd_wd;
        hval_q[qi] <= hd_v;
      end
      if (cn_inc) count_q[qi] <= count_q[qi] + CntW'(1);
      if (cn_dec && count_q[qi] != '0) count_q[qi] <= count_q[qi] - CntW'(1);
    end
  end

  assign empty_o       = !res_v_q;
  assign status_o      = res_q.status;
  assign head_index_o  = res_q.head_index;
  assign queue_empty_o = res_q.queue_empty;
  assign queue_count_o = res_q.queue_count;

  `CLQ_ASSERT(a_onehot, clk_i, rst_ni, $onehot(state_q), "back state not one-hot")
  `CLQ_ASSERT_NEVER(a_take_busy, clk_i, rst_ni, cmd_take_o && state_q != ST_IDLE,
                    "command taken while busy")
  `CLQ_ASSERT(a_load_free, clk_i, rst_ni, res_load |-> (!res_v_q || pop_i),
              "result overwritten before transfer")
endmodule
`default_nettype wire

// File: design/circular_linked_queue_manager.sv
// Top level of the circular linked queue manager.
// Depends on clqm_pkg, clqm_front and clqm_back.
`timescale 1ns / 1ps
`default_nettype none
// The block keeps up to NUM_QUEUES circular doubly linked queues over a pool
// of NUM_ELEMENTS slots. Requests enter through a queue-style port (push,
// full) and each gives exactly one result, read through a second queue-style
// port (empty, pop). The front end range-checks requests and holds two of
// them, so a user can push while the back end works. The back end handles
// one request at a time against link memories with one write and one read
// port each and registered reads; a remove walks the queue from its head,
// element by element, until it finds the element or returns to the head.
// After reset the back end sweeps the link memories before it starts on the
// first request; requests pushed meanwhile wait in the front queue. A
// finished result sits in an output register, and the next request proceeds
// until its own result would overwrite one that has not been transferred yet.
module circular_linked_queue_manager #(
  parameter int unsigned NUM_ELEMENTS = 64,
  parameter int unsigned NUM_QUEUES   = 4
) (
  input  wire                         clk_i,
  input  wire                         rst_ni,
  input  wire                         push,
  output logic                        full,
  input  wire                         kind_i,
  input  wire [clqm_pkg::QidW-1:0]    queue_id_i,
  input  wire [clqm_pkg::ElemW-1:0]   element_i,
  output logic                        empty,
  input  wire                         pop,
  output logic                        status_o,
  output logic [clqm_pkg::ElemW-1:0]  head_index_o,
  output logic                        queue_empty_o,
  output logic [clqm_pkg::CntW-1:0]   queue_count_o
);
  import clqm_pkg::*;

  // Commands pass from front to back through the front's small queue.
  cmd_t cmd;
  logic cmd_valid;
  logic cmd_take;

  clqm_front #(
    .NUM_ELEMENTS(NUM_ELEMENTS),
    .NUM_QUEUES  (NUM_QUEUES)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .full_o     (full),
    .kind_i     (kind_i),
    .queue_id_i (queue_id_i),
    .element_i  (element_i),
    .cmd_valid_o(cmd_valid),
    .cmd_take_i (cmd_take),
    .cmd_o      (cmd)
  );

  // The back end owns all list state and the result register.
  clqm_back #(
    .NUM_ELEMENTS(NUM_ELEMENTS),
    .NUM_QUEUES  (NUM_QUEUES)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_valid_i  (cmd_valid),
    .cmd_take_o   (cmd_take),
    .cmd_i        (cmd),
    .empty_o      (empty),
    .pop_i        (pop),
    .status_o     (status_o),
    .head_index_o (head_index_o),
    .queue_empty_o(queue_empty_o),
    .queue_count_o(queue_count_o)
  );
endmodule
`default_nettype wire

// File: verif/clqm_checker.sv
// Checker for the circular linked queue manager: predicts each result from the
// accepted requests and compares it with the delivered result. Depends on clqm_pkg.
`timescale 1ns / 1ps
`default_nettype none
module clqm_checker (
  input  wire                              clk_i,
  input  wire                              rst_ni,
  input  wire                              push,
  input  wire                              full,
  input  wire                              kind_i,
  input  wire [clqm_pkg::QidW-1:0]         queue_id_i,
  input  wire [clqm_pkg::ElemW-1:0]        element_i,
  input  wire                              empty,
  input  wire                              pop,
  input  wire                              status_o,
  input  wire [clqm_pkg::ElemW-1:0]        head_index_o,
  input  wire                              queue_empty_o,
  input  wire [clqm_pkg::CntW-1:0]         queue_count_o,
  output int                               fail_count_o,
  output int                               pending_o,
  output logic                             transfer_o
);
  import clqm_pkg::*;

  localparam int NumSlots = 64;
  localparam int NumQ     = 4;

  logic [ElemW-1:0] nxt [NumSlots];
  logic [ElemW-1:0] prv [NumSlots];
  logic             linked [NumSlots];
  logic [ElemW-1:0] head [NumQ];
  logic             occupied [NumQ];
  logic [CntW-1:0]  count [NumQ];
  res_t             expected_results [$];

  function automatic bit found_in_queue(int q, int e);
    int cur;
    if (!occupied[q]) return 0;
    cur = head[q];
    for (int i = 0; i < NumSlots; i++) begin
      if (cur == e) return 1;
      cur = nxt[cur];
      if (cur == head[q]) break;
    end
    return 0;
  endfunction

  function automatic res_t apply_request(kind_e kind, int q, int e);
    res_t r;
    int h, t, p, n;
    r.status = STATUS_REJECTED;
    if (kind == KIND_APPEND) begin
      if (!linked[e]) begin
        if (!occupied[q]) begin
          head[q] = e;
          occupied[q] = 1'b1;
          nxt[e] = e;
          prv[e] = e;
        end else begin
          h = head[q];
          t = prv[h];
          prv[e] = t;
          nxt[e] = h;
          nxt[t] = e;
          prv[h] = e;
        end
        linked[e] = 1'b1;
        count[q]++;
        r.status = STATUS_DONE;
      end
    end else if (found_in_queue(q, e)) begin
      p = prv[e];
      n = nxt[e];
      if (n == e) begin
        occupied[q] = 1'b0;
        head[q] = '0;
      end else begin
        nxt[p] = n;
        prv[n] = p;
        if (head[q] == e) head[q] = n;
      end
      nxt[e] = '0;
      prv[e] = '0;
      linked[e] = 1'b0;
      if (count[q] != 0) count[q]--;
      r.status = STATUS_DONE;
    end
    r.head_index  = occupied[q] ? head[q] : '0;
    r.queue_empty = !occupied[q];
    r.queue_count = count[q];
    return r;
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    $display("%0t: mismatch on %s: got %0d, expected %0d", $realtime, what, got, want);
    fail_count_o++;
  endtask

  assign pending_o = expected_results.size();
  assign transfer_o = (push && !full) || (pop && !empty);

  initial begin
    fail_count_o = 0;
    for (int i = 0; i < NumSlots; i++) begin
      nxt[i] = '0;
      prv[i] = '0;
      linked[i] = 1'b0;
    end
    for (int i = 0; i < NumQ; i++) begin
      head[i] = '0;
      occupied[i] = 1'b0;
      count[i] = '0;
    end
  end

  always @(posedge clk_i) begin
    res_t want;
    if (rst_ni) begin
      if (push && !full)
        expected_results.push_back(apply_request(kind_e'(kind_i), queue_id_i, element_i));
      if (pop && !empty) begin
        if (expected_results.size() == 0) begin
          $display("%0t: result delivered with none expected", $realtime);
          fail_count_o++;
        end else begin
          want = expected_results.pop_front();
          if (status_o != want.status) report_mismatch("status", status_o, want.status);
          if (head_index_o != want.head_index)
            report_mismatch("head_index", head_index_o, want.head_index);
          if (queue_empty_o != want.queue_empty)
            report_mismatch("queue_empty", queue_empty_o, want.queue_empty);
          if (queue_count_o != want.queue_count)
            report_mismatch("queue_count", queue_count_o, want.queue_count);
        end
      end
    end
  end
endmodule
`default_nettype wire

// File: verif/testbench.sv
// Top of the circular linked queue manager testbench: clock, reset, request
// stimulus, result draining and the verdict. Depends on clqm_pkg and clqm_checker.
`timescale 1ns / 1ps
`default_nettype none
module testbench;
  import clqm_pkg::*;

  localparam int RandomRequests = 600;
  // No transfer for this many cycles means the block has hung. The limit is
  // several times the slowest legal gap: a full-length walk plus the longest
  // random stall on each side per transfer.
  localparam int StallLimit = 2000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic push = 1'b0;
  logic pop = 1'b0;
  logic kind = 1'b0;
  logic [QidW-1:0] queue_id = '0;
  logic [ElemW-1:0] element = '0;
  wire full, empty, status, queue_empty;
  wire [ElemW-1:0] head_index;
  wire [CntW-1:0] queue_count;
  int fail_count, pending;
  logic transfer;
  bit burst_mode = 1'b0;    // when set, neither side inserts idle cycles
  int idle_cycles = 0;

  // The mirror of which queue holds each slot lets the random part build
  // mostly meaningful requests: appends of free slots, removes of members.
  int slot_owner [64];

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  circular_linked_queue_manager dut (
    .clk_i(clk), .rst_ni(rst_n), .push(push), .full(full),
    .kind_i(kind), .queue_id_i(queue_id), .element_i(element),
    .empty(empty), .pop(pop), .status_o(status), .head_index_o(head_index),
    .queue_empty_o(queue_empty), .queue_count_o(queue_count)
  );

  clqm_checker u_checker (
    .clk_i(clk), .rst_ni(rst_n), .push(push), .full(full),
    .kind_i(kind), .queue_id_i(queue_id), .element_i(element),
    .empty(empty), .pop(pop), .status_o(status), .head_index_o(head_index),
    .queue_empty_o(queue_empty), .queue_count_o(queue_count),
    .fail_count_o(fail_count), .pending_o(pending), .transfer_o(transfer)
  );

  // Sends one request: waits its random gap, then holds push until the
  // transfer happens. Push is dropped after the transfer only when a gap
  // follows; when no gap follows, the next call keeps it high.
  task automatic send_request(kind_e k, int q, int e);
    int gap;
    gap = burst_mode ? 0 : $urandom_range(0, 15);
    if (gap != 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    push <= 1'b1;
    kind <= k;
    queue_id <= q;
    element <= e;
    @(posedge clk);
    while (full) @(posedge clk);
    // Track slot ownership as the block should see it.
    if (k == KIND_APPEND && slot_owner[e] < 0) slot_owner[e] = q;
    else if (k == KIND_REMOVE && slot_owner[e] == q) slot_owner[e] = -1;
  endtask

  task automatic release_push();
    push <= 1'b0;
    @(posedge clk);
  endtask

  // Result side: pop with a random stall before each transfer.
  initial begin
    int stall;
    @(posedge rst_n);
    forever begin
      stall = burst_mode ? 0 : $urandom_range(0, 15);
      if (stall != 0) begin
        pop <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      pop <= 1'b1;
      @(posedge clk);
      while (empty) @(posedge clk);
    end
  end

  // Watchdog on cycles without any transfer.
  always @(posedge clk) begin
    if (transfer || !rst_n) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= StallLimit) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  initial begin
    int q, e, pick;
    for (int i = 0; i < 64; i++) slot_owner[i] = -1;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part: empty-queue remove, extreme slots and queues, cross-queue
    // rejects, head removal, and emptying a queue.
    send_request(KIND_REMOVE, 0, 0);
    send_request(KIND_APPEND, 0, 0);
    send_request(KIND_APPEND, 0, 63);
    send_request(KIND_APPEND, 0, 21);
    send_request(KIND_APPEND, 3, 63);      // slot already linked elsewhere
    send_request(KIND_APPEND, 0, 0);       // slot already linked here
    send_request(KIND_REMOVE, 3, 0);       // slot sits in another queue
    send_request(KIND_APPEND, 3, 42);
    send_request(KIND_REMOVE, 0, 0);       // head moves to the next element
    send_request(KIND_REMOVE, 0, 21);      // tail removal
    send_request(KIND_REMOVE, 0, 21);      // no longer present
    send_request(KIND_REMOVE, 0, 63);      // queue becomes empty
    send_request(KIND_REMOVE, 3, 42);
    send_request(KIND_APPEND, 1, 1);
    send_request(KIND_APPEND, 2, 62);
    send_request(KIND_REMOVE, 2, 62);
    send_request(KIND_REMOVE, 1, 1);

    // Pause the sender until every result is back.
    release_push();
    while (pending != 0) @(posedge clk);

    // Fill one queue with all slots, then drain it, to walk the full length.
    burst_mode = 1'b1;
    for (int i = 0; i < 64; i++) send_request(KIND_APPEND, 2, i);
    for (int i = 63; i >= 0; i--) send_request(KIND_REMOVE, 2, i);
    burst_mode = 1'b0;

    for (int n = 0; n < RandomRequests; n++) begin
      if (n % 150 == 100) burst_mode = 1'b1;
      if (n % 150 == 130) burst_mode = 1'b0;
      q = $urandom_range(0, 3);
      e = $urandom_range(0, 63);
      pick = $urandom_range(0, 9);
      if (pick < 8) begin
        // Well-formed: remove a member of the queue if the slot has an owner,
        // otherwise append it.
        if (slot_owner[e] >= 0) send_request(KIND_REMOVE, slot_owner[e], e);
        else send_request(KIND_APPEND, q, e);
      end else begin
        send_request(kind_e'($urandom_range(0, 1)), q, e);
      end
    end
    release_push();
    while (pending != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (fail_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end
endmodule
`default_nettype wire
